@@ design/rabs_pkg.sv @@
package rabs_pkg;

    localparam int MAX_PIXELS_DEFAULT = 524288;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_ADDR_W-1:0] CFG_DIFF_THRESHOLD = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LEARN_RATE     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_PIXELS   = 2'd2;

    localparam logic [7:0]  DIFF_THRESHOLD_RESET = 8'd40;
    localparam logic [15:0] LEARN_RATE_RESET     = 16'd3277;
    localparam logic [19:0] FRAME_PIXELS_RESET   = 20'd307200;

    localparam logic [13:0] LUMA_R     = 14'd4899;
    localparam logic [13:0] LUMA_G     = 14'd9617;
    localparam logic [13:0] LUMA_B     = 14'd1868;
    localparam logic [13:0] LUMA_ROUND = 14'd8192;

    typedef struct packed {
        logic        foreground;
        logic [15:0] bg_next;
    } upd_t;

endpackage

@@ design/rabs_luma.sv @@
module rabs_luma
    import rabs_pkg::*;
(
    input  logic [7:0] blue,
    input  logic [7:0] green,
    input  logic [7:0] red,
    output logic [7:0] gray
);

    logic [21:0] weighted_sum;

    assign weighted_sum = 22'(LUMA_R) * 22'(red)
                        + 22'(LUMA_G) * 22'(green)
                        + 22'(LUMA_B) * 22'(blue)
                        + 22'(LUMA_ROUND);

    assign gray = weighted_sum[21:14];

endmodule

@@ design/rabs_bg_ram.sv @@
module rabs_bg_ram
    import rabs_pkg::*;
#(
    parameter int DEPTH  = MAX_PIXELS_DEFAULT,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [15:0]       wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [15:0]       rd_data
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/rabs_update.sv @@
module rabs_update
    import rabs_pkg::*;
(
    input  logic [7:0]  gray,
    input  logic [15:0] stored,
    input  logic        first_frame,
    input  logic [7:0]  diff_threshold,
    input  logic [15:0] learn_rate,
    output upd_t        result
);

    logic [16:0]        round_sum;
    logic [8:0]         bg_round;
    logic [7:0]         bg8;
    logic [7:0]         abs_diff;
    logic signed [17:0] delta;
    logic signed [34:0] product;
    logic signed [35:0] acc;
    logic [19:0]        scaled;
    logic [15:0]        bg_blend;

    assign round_sum = 17'(stored) + 17'd128;
    assign bg_round  = round_sum[16:8];
    assign bg8       = (bg_round > 9'd255) ? 8'hFF : bg_round[7:0];
    assign abs_diff  = (gray >= bg8) ? (gray - bg8) : (bg8 - gray);

    // The blend stored*(1-a) + gray*a is rewritten as stored + a*(gray - stored).
    assign delta   = $signed({2'b00, gray, 8'h00}) - $signed({2'b00, stored});
    assign product = delta * $signed({1'b0, learn_rate});
    assign acc     = $signed({4'h0, stored, 16'h0000}) + 36'(product) + 36'sd32768;
    assign scaled  = acc[35:16];
    assign bg_blend = (scaled > 20'd65535) ? 16'hFFFF : scaled[15:0];

    always_comb begin
        if (first_frame) begin
            result.foreground = 1'b0;
            result.bg_next    = {gray, 8'h00};
        end else begin
            result.foreground = (abs_diff > diff_threshold);
            result.bg_next    = bg_blend;
        end
    end

endmodule

@@ design/running_average_background_subtractor.sv @@
// Channel  Direction  tdata                         tuser        tlast
// s_       in         [7:0] blue [15:8] green       -            -
//                     [23:16] red
// m_       out        [0] foreground, rest zero     mask_valid   end_of_frame
//
// One pixel is accepted per cycle while s_tready is high; the pixel is registered in the middle
// stage, and its result is loaded from there into the output registers, from which it is taken.
// The background memory is read when the pixel is accepted and written when the item leaves
// the middle stage; a pixel that reads the entry being written takes the new value by forwarding.
// Reset clears the pixel position and sets the first-frame state; the memory is not cleared.
// Two output registers absorb a stall on m_tready; once both are full and the middle stage holds
// an item, s_tready drops until an output item is taken.
module running_average_background_subtractor
    import rabs_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // blue, green, red
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // foreground, zero fill
    output logic                  m_tuser,   // mask_valid
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int LEN_W  = (ADDR_W + 1 > 20) ? ADDR_W + 1 : 20;

    logic [7:0]        diff_threshold_reg;
    logic [15:0]       learn_rate_reg;
    logic [19:0]       frame_pixels_reg;

    logic [ADDR_W-1:0] pos_reg;
    logic [ADDR_W-1:0] pos_next;
    logic              first_frame_reg;

    logic              s1_valid_reg;
    logic [7:0]        s1_gray_reg;
    logic              s1_first_reg;
    logic              s1_eof_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              s1_fwd_reg;
    logic [15:0]       s1_fwd_data_reg;

    logic              out_valid_reg;
    logic              out_fg_reg;
    logic              out_mv_reg;
    logic              out_eof_reg;
    logic              skid_valid_reg;
    logic              skid_fg_reg;
    logic              skid_mv_reg;
    logic              skid_eof_reg;

    logic [7:0]        gray;
    logic [LEN_W-1:0]  frame_ext;
    logic [LEN_W-1:0]  frame_len;
    logic              eof;
    logic              accept;
    logic              s1_adv;
    logic              m_take;
    logic [15:0]       ram_rdata;
    logic [15:0]       stored;
    upd_t              upd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diff_threshold_reg <= DIFF_THRESHOLD_RESET;
            learn_rate_reg     <= LEARN_RATE_RESET;
            frame_pixels_reg   <= FRAME_PIXELS_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_DIFF_THRESHOLD: diff_threshold_reg <= cfg_wdata[7:0];
                CFG_LEARN_RATE:     learn_rate_reg     <= cfg_wdata[15:0];
                CFG_FRAME_PIXELS:   frame_pixels_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    rabs_luma u_luma (
        .blue  (s_tdata[7:0]),
        .green (s_tdata[15:8]),
        .red   (s_tdata[23:16]),
        .gray  (gray)
    );

    assign frame_ext = LEN_W'(frame_pixels_reg);

    always_comb begin
        if (frame_ext == '0) begin
            frame_len = LEN_W'(1);
        end else if (frame_ext > LEN_W'(MAX_PIXELS)) begin
            frame_len = LEN_W'(MAX_PIXELS);
        end else begin
            frame_len = frame_ext;
        end
    end

    assign eof      = (LEN_W'(pos_reg) >= frame_len - LEN_W'(1));
    assign pos_next = eof ? '0 : pos_reg + ADDR_W'(1);

    assign s1_adv   = s1_valid_reg && !skid_valid_reg;
    assign s_tready = !s1_valid_reg || !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign m_take   = out_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= '0;
            first_frame_reg <= 1'b1;
        end else if (accept) begin
            pos_reg <= pos_next;
            if (eof) begin
                first_frame_reg <= 1'b0;
            end
        end
    end

    rabs_bg_ram #(
        .DEPTH  (MAX_PIXELS),
        .ADDR_W (ADDR_W)
    ) u_bg_ram (
        .aclk    (aclk),
        .wr_en   (s1_adv),
        .wr_addr (s1_addr_reg),
        .wr_data (upd.bg_next),
        .rd_en   (accept),
        .rd_addr (pos_reg),
        .rd_data (ram_rdata)
    );

    assign stored = s1_fwd_reg ? s1_fwd_data_reg : ram_rdata;

    rabs_update u_update (
        .gray           (s1_gray_reg),
        .stored         (stored),
        .first_frame    (s1_first_reg),
        .diff_threshold (diff_threshold_reg),
        .learn_rate     (learn_rate_reg),
        .result         (upd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_gray_reg     <= gray;
            s1_first_reg    <= first_frame_reg;
            s1_eof_reg      <= eof;
            s1_addr_reg     <= pos_reg;
            s1_fwd_reg      <= s1_valid_reg && (s1_addr_reg == pos_reg);
            s1_fwd_data_reg <= upd.bg_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_take) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= s1_adv;
            end
        end else if (s1_adv) begin
            if (out_valid_reg) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (m_take && skid_valid_reg) begin
            out_fg_reg  <= skid_fg_reg;
            out_mv_reg  <= skid_mv_reg;
            out_eof_reg <= skid_eof_reg;
        end else if (s1_adv && (m_take || !out_valid_reg)) begin
            out_fg_reg  <= upd.foreground;
            out_mv_reg  <= !s1_first_reg;
            out_eof_reg <= s1_eof_reg;
        end
        if (s1_adv && out_valid_reg && !m_take) begin
            skid_fg_reg  <= upd.foreground;
            skid_mv_reg  <= !s1_first_reg;
            skid_eof_reg <= s1_eof_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0000000, out_fg_reg};
    assign m_tuser  = out_mv_reg;
    assign m_tlast  = out_eof_reg;

endmodule

@@ test/running_average_background_subtractor_tb.sv @@
`timescale 1ns / 100ps

module running_average_background_subtractor_tb;
    import rabs_pkg::*;

    localparam int FIRST_FRAME_LEN = 13;
    localparam int RANDOM_PIXELS = 380;
    localparam int SETTLE_CYCLES = 6;

    typedef struct packed {
        logic foreground;
        logic mask_valid;
        logic end_of_frame;
    } mask_result_t;

    typedef enum logic {
        ROW_PIXEL,
        ROW_WRITE
    } row_kind_e;

    typedef struct packed {
        row_kind_e             kind;
        logic [CFG_ADDR_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0] value;
        logic [7:0]            blue;
        logic [7:0]            green;
        logic [7:0]            red;
        logic                  typed;
        mask_result_t          want;
    } stim_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata = '0;   // [7:0] blue, [15:8] green, [23:16] red
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;        // [0] foreground, [7:1] zero
    logic                  m_tuser;        // mask_valid
    logic                  m_tlast;        // end_of_frame
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic [15:0]    bg_store [int unsigned];
    int unsigned    pix_pos = 0;
    bit             loading_frame = 1'b1;
    logic [7:0]     thresh_q = DIFF_THRESHOLD_RESET;
    logic [15:0]    alpha_q = LEARN_RATE_RESET;
    logic [19:0]    frame_len_q = FRAME_PIXELS_RESET;

    mask_result_t   pending_masks [$];
    mask_result_t   oldest_mask;
    int             mismatches = 0;
    bit             tx_steady = 1'b0;
    bit             rx_steady = 1'b0;
    int             rx_hold = 0;

    running_average_background_subtractor DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic mask_result_t predict_mask(logic [7:0] b, logic [7:0] g, logic [7:0] r);
        int unsigned     gray;
        int unsigned     flen;
        int unsigned     pos;
        int unsigned     bg8;
        int unsigned     diff;
        logic [15:0]     stored;
        longint unsigned acc;
        mask_result_t    res;
        gray = (32'd4899 * r + 32'd9617 * g + 32'd1868 * b + 32'd8192) >> 14;
        flen = frame_len_q;
        if (flen == 0) flen = 1;
        if (flen > MAX_PIXELS_DEFAULT) flen = MAX_PIXELS_DEFAULT;
        pos = pix_pos;
        res = '0;
        res.end_of_frame = (pos >= flen - 1);
        if (pos >= MAX_PIXELS_DEFAULT) pos = MAX_PIXELS_DEFAULT - 1;
        if (loading_frame) begin
            bg_store[pos] = 16'(gray << 8);
        end else begin
            if (!bg_store.exists(pos)) begin
                $error("background entry %0d read before it was written", pos);
                mismatches++;
                bg_store[pos] = '0;
            end
            stored = bg_store[pos];
            bg8 = (32'(stored) + 32'd128) >> 8;
            if (bg8 > 255) bg8 = 255;
            diff = (gray > bg8) ? gray - bg8 : bg8 - gray;
            res.foreground = (diff > thresh_q);
            res.mask_valid = 1'b1;
            acc = 64'(stored) * (64'd65536 - 64'(alpha_q)) + 64'(gray << 8) * 64'(alpha_q)
                + 64'd32768;
            acc = acc >> 16;
            if (acc > 64'd65535) acc = 64'd65535;
            bg_store[pos] = 16'(acc);
        end
        if (res.end_of_frame) begin
            pix_pos = 0;
            loading_frame = 1'b0;
        end else begin
            pix_pos = pos + 1;
        end
        return res;
    endfunction

    function automatic stim_row_t pixel_row(logic [7:0] b, logic [7:0] g, logic [7:0] r);
        stim_row_t row;
        row = '0;
        row.kind = ROW_PIXEL;
        row.blue = b;
        row.green = g;
        row.red = r;
        return row;
    endfunction

    function automatic stim_row_t checked_row(logic [7:0] b, logic [7:0] g, logic [7:0] r,
                                              logic fg, logic valid, logic eof);
        stim_row_t row;
        row = pixel_row(b, g, r);
        row.typed = 1'b1;
        row.want.foreground = fg;
        row.want.mask_valid = valid;
        row.want.end_of_frame = eof;
        return row;
    endfunction

    function automatic stim_row_t write_row(logic [CFG_ADDR_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] value);
        stim_row_t row;
        row = '0;
        row.kind = ROW_WRITE;
        row.reg_idx = idx;
        row.value = value;
        return row;
    endfunction

    task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                              input logic typed, input mask_result_t want);
        int           gap;
        mask_result_t predicted;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {r, g, b};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = predict_mask(b, g, r);
        pending_masks.push_back(typed ? want : predicted);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_masks.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DIFF_THRESHOLD: thresh_q = value[7:0];
            CFG_LEARN_RATE:     alpha_q = value[15:0];
            CFG_FRAME_PIXELS:   frame_len_q = value[19:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            m_tready <= 1'b1;
            if (!rx_steady) rx_hold = pick_gap();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_masks.size() == 0) begin
                $error("result item with no pixel waiting for it");
                mismatches++;
            end else begin
                oldest_mask = pending_masks.pop_front();
                if (m_tdata[0] !== oldest_mask.foreground) begin
                    $error("foreground: expected %0d, got %0d",
                           oldest_mask.foreground, m_tdata[0]);
                    mismatches++;
                end
                if (m_tdata[7:1] !== 7'd0) begin
                    $error("tdata fill: expected 0, got %0h", m_tdata[7:1]);
                    mismatches++;
                end
                if (m_tuser !== oldest_mask.mask_valid) begin
                    $error("mask_valid: expected %0d, got %0d",
                           oldest_mask.mask_valid, m_tuser);
                    mismatches++;
                end
                if (m_tlast !== oldest_mask.end_of_frame) begin
                    $error("end_of_frame: expected %0d, got %0d",
                           oldest_mask.end_of_frame, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        stim_row_t   directed_rows [$];
        stim_row_t   row;
        logic [7:0]  b;
        logic [7:0]  g;
        logic [7:0]  r;
        logic [15:0] stored;
        int          random_pixels;
        int          phase_len;
        int          bg8;
        int          lvl;

        // The first frame is opened with an oversized length and then cut short,
        // so that it loads exactly FIRST_FRAME_LEN background entries.
        directed_rows = '{
            write_row(CFG_FRAME_PIXELS, 20'hFFFFF),
            checked_row(8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 1'b0),
            checked_row(8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0),
            checked_row(8'd255, 8'd0,   8'd0,   1'b0, 1'b0, 1'b0),
            checked_row(8'd0,   8'd255, 8'd0,   1'b0, 1'b0, 1'b0),
            checked_row(8'd0,   8'd0,   8'd255, 1'b0, 1'b0, 1'b0),
            checked_row(8'd128, 8'd128, 8'd128, 1'b0, 1'b0, 1'b0),
            checked_row(8'h55,  8'hAA,  8'h55,  1'b0, 1'b0, 1'b0),
            checked_row(8'hAA,  8'h55,  8'hAA,  1'b0, 1'b0, 1'b0),
            checked_row(8'd1,   8'd1,   8'd1,   1'b0, 1'b0, 1'b0),
            checked_row(8'd254, 8'd254, 8'd254, 1'b0, 1'b0, 1'b0),
            checked_row(8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 1'b0),
            checked_row(8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0),
            write_row(CFG_FRAME_PIXELS, 20'd3),
            checked_row(8'd100, 8'd100, 8'd100, 1'b0, 1'b0, 1'b1),
            checked_row(8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 1'b0),
            checked_row(8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 1'b0),
            checked_row(8'd0,   8'd0,   8'd0,   1'b0, 1'b1, 1'b1),
            write_row(CFG_DIFF_THRESHOLD, 20'd255),
            write_row(CFG_LEARN_RATE, 20'd0),
            checked_row(8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 1'b0),
            checked_row(8'd0,   8'd0,   8'd0,   1'b0, 1'b1, 1'b0),
            checked_row(8'd255, 8'd0,   8'd255, 1'b0, 1'b1, 1'b1),
            write_row(CFG_DIFF_THRESHOLD, 20'd0),
            write_row(CFG_LEARN_RATE, 20'hFFFF),
            pixel_row(8'd128, 8'd64,  8'd32),
            pixel_row(8'd255, 8'd255, 8'd255),
            pixel_row(8'd0,   8'd0,   8'd0),
            write_row(CFG_FRAME_PIXELS, 20'd0),
            pixel_row(8'd255, 8'd255, 8'd255),
            pixel_row(8'd0,   8'd0,   8'd0),
            write_row(CFG_FRAME_PIXELS, 20'd1),
            pixel_row(8'd10,  8'd20,  8'd30)
        };

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_WRITE) begin
                drain_results();
                write_reg(row.reg_idx, row.value);
            end else begin
                send_pixel(row.blue, row.green, row.red, row.typed, row.want);
            end
        end

        random_pixels = 0;
        while (random_pixels < RANDOM_PIXELS) begin
            drain_results();
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 3))
                    0: write_reg(CFG_DIFF_THRESHOLD, 20'd0);
                    1: write_reg(CFG_DIFF_THRESHOLD, 20'd255);
                    2: write_reg(CFG_DIFF_THRESHOLD, 20'($urandom_range(0, 255)));
                    default: write_reg(CFG_DIFF_THRESHOLD, 20'($urandom_range(0, 20)));
                endcase
            end
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 3))
                    0: write_reg(CFG_LEARN_RATE, 20'd0);
                    1: write_reg(CFG_LEARN_RATE, 20'hFFFF);
                    2: write_reg(CFG_LEARN_RATE, 20'($urandom_range(0, 65535)));
                    default: write_reg(CFG_LEARN_RATE, 20'($urandom_range(1000, 6000)));
                endcase
            end
            // Lengths never exceed the first frame, so every entry read was loaded.
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_FRAME_PIXELS, 20'($urandom_range(0, FIRST_FRAME_LEN)));
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(5, 40);
            repeat (phase_len) begin
                case ($urandom_range(0, 4))
                    0, 1: begin
                        b = 8'($urandom_range(0, 255));
                        g = 8'($urandom_range(0, 255));
                        r = 8'($urandom_range(0, 255));
                    end
                    2, 3: begin
                        // A gray level just at or past the threshold from the background.
                        stored = bg_store.exists(pix_pos) ? bg_store[pix_pos] : 16'd0;
                        bg8 = (int'(stored) + 128) >> 8;
                        if (bg8 > 255) bg8 = 255;
                        lvl = int'(thresh_q) + int'($urandom_range(0, 1));
                        lvl = $urandom_range(0, 1) ? bg8 + lvl : bg8 - lvl;
                        if (lvl < 0) lvl = 0;
                        if (lvl > 255) lvl = 255;
                        b = 8'(lvl);
                        g = 8'(lvl);
                        r = 8'(lvl);
                    end
                    default: begin
                        b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                        g = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                        r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    end
                endcase
                send_pixel(b, g, r, 1'b0, '0);
                random_pixels++;
            end
        end

        drain_results();
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/rabs_pkg.sv
design/rabs_luma.sv
design/rabs_bg_ram.sv
design/rabs_update.sv
design/running_average_background_subtractor.sv
test/running_average_background_subtractor_tb.sv
